// ----- rtl/core/bstf_pkg.sv -----
// ----------------------------------------------------------------------------
// bstf_pkg
// Shared types and operation codes for the level-order tree fill block.
// ----------------------------------------------------------------------------
package bstf_pkg;

   localparam int OP_BITS = 5;

   // controller states, also sent to the datapath as the operation to run
   localparam logic [OP_BITS-1:0] OP_LOAD     = 5'd0;
   localparam logic [OP_BITS-1:0] OP_RK_I     = 5'd1;
   localparam logic [OP_BITS-1:0] OP_RK_J0    = 5'd2;
   localparam logic [OP_BITS-1:0] OP_RK_J     = 5'd3;
   localparam logic [OP_BITS-1:0] OP_RK_W     = 5'd4;
   localparam logic [OP_BITS-1:0] OP_PL_PUSH  = 5'd5;
   localparam logic [OP_BITS-1:0] OP_PL_LEFT  = 5'd6;
   localparam logic [OP_BITS-1:0] OP_PL_POP   = 5'd7;
   localparam logic [OP_BITS-1:0] OP_PL_POPW  = 5'd8;
   localparam logic [OP_BITS-1:0] OP_PL_FILL  = 5'd9;
   localparam logic [OP_BITS-1:0] OP_BF_HEAD  = 5'd10;
   localparam logic [OP_BITS-1:0] OP_BF_RD    = 5'd11;
   localparam logic [OP_BITS-1:0] OP_BF_L     = 5'd12;
   localparam logic [OP_BITS-1:0] OP_BF_R     = 5'd13;
   localparam logic [OP_BITS-1:0] OP_OUT_Q    = 5'd14;
   localparam logic [OP_BITS-1:0] OP_OUT_K    = 5'd15;
   localparam logic [OP_BITS-1:0] OP_OUT_WAIT = 5'd16;

   localparam int CHILD_BITS = 7;
   localparam int KEY_IN_BITS = 32;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 32;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic req_fire;
      logic req_last;
      logic rsp_fire;
      logic left_ok;
      logic right_ok;
      logic j_end;
      logic i_end;
      logic sp_zero;
      logic q_empty;
      logic out_last;
   } status_type;

endpackage

// ----- rtl/core/bstf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bstf_ctrl
// Sequencer: load, rank sort, in-order placement, breadth-first walk, output.
// ----------------------------------------------------------------------------
module bstf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  bstf_pkg::status_type status,
   output bstf_pkg::cmd_type    cmd
);
   import bstf_pkg::*;

   logic [OP_BITS-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         OP_LOAD:     if (status.req_fire && status.req_last) state_in = OP_RK_I;
         OP_RK_I:     state_in = OP_RK_J0;
         OP_RK_J0:    state_in = OP_RK_J;
         OP_RK_J:     if (status.j_end) state_in = OP_RK_W;
         OP_RK_W:     state_in = status.i_end ? OP_PL_PUSH : OP_RK_I;
         OP_PL_PUSH:  state_in = OP_PL_LEFT;
         OP_PL_LEFT:  state_in = status.left_ok ? OP_PL_PUSH : OP_PL_POP;
         OP_PL_POP:   state_in = status.sp_zero ? OP_BF_HEAD : OP_PL_POPW;
         OP_PL_POPW:  state_in = OP_PL_FILL;
         OP_PL_FILL:  state_in = status.right_ok ? OP_PL_PUSH : OP_PL_POP;
         OP_BF_HEAD:  state_in = status.q_empty ? OP_OUT_Q : OP_BF_RD;
         OP_BF_RD:    state_in = OP_BF_L;
         OP_BF_L:     state_in = OP_BF_R;
         OP_BF_R:     state_in = OP_BF_HEAD;
         OP_OUT_Q:    state_in = OP_OUT_K;
         OP_OUT_K:    state_in = OP_OUT_WAIT;
         OP_OUT_WAIT: if (status.rsp_fire) state_in = status.out_last ? OP_LOAD : OP_OUT_Q;
         default:     state_in = OP_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.op = state_ff;

endmodule

// ----- rtl/core/bstf_dp.sv -----
// ----------------------------------------------------------------------------
// bstf_dp
// Datapath: node memories, stack, queue, walk registers and result register.
// ----------------------------------------------------------------------------
module bstf_dp #(
   parameter int MAX_NODES = 64,
   parameter int KEY_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bstf_pkg::cmd_type                   cmd,
   output bstf_pkg::status_type                status,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bstf_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bstf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);
   import bstf_pkg::*;

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int UW = (CW > CHILD_BITS) ? CW : CHILD_BITS;
   localparam int LW = 2 * CHILD_BITS;

   // memories
   logic [LW-1:0]       link_mem [MAX_NODES];
   logic [KEY_BITS-1:0] key_mem  [MAX_NODES];
   logic [KEY_BITS-1:0] srt_mem  [MAX_NODES];
   logic [KEY_BITS-1:0] nkey_mem [MAX_NODES];
   logic [IW-1:0]       stk_mem  [MAX_NODES];
   logic [IW-1:0]       que_mem  [MAX_NODES];

   logic [LW-1:0]       link_rd;
   logic [KEY_BITS-1:0] key_rd, srt_rd, nkey_rd;
   logic [IW-1:0]       stk_rd, que_rd;

   logic                link_we, link_re, key_we, key_re, srt_we, srt_re;
   logic                nkey_we, nkey_re, stk_we, stk_re, que_we, que_re;
   logic [IW-1:0]       link_wa, link_ra, key_wa, key_ra, srt_wa, srt_ra;
   logic [IW-1:0]       nkey_wa, nkey_ra, stk_wa, stk_ra, que_wa, que_ra;
   logic [KEY_BITS-1:0] srt_wd, nkey_wd;
   logic [IW-1:0]       stk_wd, que_wd;

   // control registers
   logic [CW-1:0]        count_ff, count_in;
   logic [IW-1:0]        i_ff, i_in, j_ff, j_in, rank_ff, rank_in, cur_ff, cur_in;
   logic [CW-1:0]        fill_ff, fill_in, sp_ff, sp_in;
   logic [CW-1:0]        head_ff, head_in, tail_ff, tail_in, k_ff, k_in;
   logic [MAX_NODES-1:0] taken_ff, taken_in;
   logic [KEY_BITS-1:0]  keyi_ff, keyi_in;
   logic                 rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [KEY_BITS-1:0]  rkey_ff, rkey_in;

   logic                 req_fire, rsp_fire, left_ok, right_ok, key_lt;
   logic [IW-1:0]        left_idx, right_idx;
   logic [CHILD_BITS-1:0] left_c, right_c;
   logic [UW-1:0]        left_ext, right_ext;

   function automatic logic [UW-1:0] child_ext(input logic [CHILD_BITS-1:0] c);
      return UW'(c[CHILD_BITS-2:0]);
   endfunction

   assign req_tready = (cmd.op == OP_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rvalid_ff && rsp_tready;

   assign left_c    = link_rd[CHILD_BITS-1:0];
   assign right_c   = link_rd[LW-1:CHILD_BITS];
   assign left_ext  = child_ext(left_c);
   assign right_ext = child_ext(right_c);
   assign left_idx  = left_ext[IW-1:0];
   assign right_idx = right_ext[IW-1:0];
   // negative or out of range means no child; an already taken node too
   assign left_ok  = !left_c[CHILD_BITS-1] && (left_ext < UW'(count_ff))
                     && !taken_ff[left_idx];
   assign right_ok = !right_c[CHILD_BITS-1] && (right_ext < UW'(count_ff))
                     && !taken_ff[right_idx];

   assign key_lt = ($signed(key_rd) < $signed(keyi_ff))
                   || ((key_rd == keyi_ff) && (j_ff < i_ff));

   assign status.req_fire = req_fire;
   assign status.req_last = req_tlast;
   assign status.rsp_fire = rsp_fire;
   assign status.left_ok  = left_ok;
   assign status.right_ok = right_ok;
   assign status.j_end    = (CW'(j_ff) + CW'(1)) == count_ff;
   assign status.i_end    = (CW'(i_ff) + CW'(1)) == count_ff;
   assign status.sp_zero  = (sp_ff == '0);
   assign status.q_empty  = (head_ff == tail_ff);
   assign status.out_last = rlast_ff;

   always_comb begin
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      rank_in   = rank_ff;
      cur_in    = cur_ff;
      fill_in   = fill_ff;
      sp_in     = sp_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      k_in      = k_ff;
      taken_in  = taken_ff;
      keyi_in   = keyi_ff;
      rvalid_in = rvalid_ff;
      rlast_in  = rlast_ff;
      rkey_in   = rkey_ff;

      link_we = 1'b0; link_re = 1'b0; link_wa = count_ff[IW-1:0]; link_ra = cur_ff;
      key_we  = 1'b0; key_re  = 1'b0; key_wa  = count_ff[IW-1:0]; key_ra  = i_ff;
      srt_we  = 1'b0; srt_re  = 1'b0; srt_wa  = rank_ff; srt_ra = fill_ff[IW-1:0];
      srt_wd  = keyi_ff;
      nkey_we = 1'b0; nkey_re = 1'b0; nkey_wa = cur_ff; nkey_ra = que_rd;
      nkey_wd = srt_rd;
      stk_we  = 1'b0; stk_re  = 1'b0; stk_wa  = sp_ff[IW-1:0]; stk_ra = sp_ff[IW-1:0];
      stk_wd  = cur_ff;
      que_we  = 1'b0; que_re  = 1'b0; que_wa  = tail_ff[IW-1:0]; que_ra = head_ff[IW-1:0];
      que_wd  = left_idx;

      case (cmd.op)
         OP_LOAD: begin
            i_in = '0;
            if (req_fire && (count_ff < CW'(MAX_NODES))) begin
               link_we  = 1'b1;
               key_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_RK_I: begin
            key_re = 1'b1;
         end
         OP_RK_J0: begin
            keyi_in = key_rd;
            rank_in = '0;
            j_in    = '0;
            key_re  = 1'b1;
            key_ra  = '0;
         end
         OP_RK_J: begin
            if (key_lt) rank_in = rank_ff + IW'(1);
            if (!status.j_end) begin
               j_in   = j_ff + IW'(1);
               key_re = 1'b1;
               key_ra = j_ff + IW'(1);
            end
         end
         OP_RK_W: begin
            srt_we = 1'b1;
            i_in   = i_ff + IW'(1);
            if (status.i_end) begin
               taken_in    = '0;
               taken_in[0] = 1'b1;
               sp_in       = '0;
               cur_in      = '0;
               fill_in     = '0;
            end
         end
         OP_PL_PUSH: begin
            stk_we  = 1'b1;
            sp_in   = sp_ff + CW'(1);
            link_re = 1'b1;
         end
         OP_PL_LEFT: begin
            if (left_ok) begin
               taken_in[left_idx] = 1'b1;
               cur_in = left_idx;
            end
         end
         OP_PL_POP: begin
            if (!status.sp_zero) begin
               sp_in  = sp_ff - CW'(1);
               stk_re = 1'b1;
               stk_ra = sp_in[IW-1:0];
            end else begin
               // placement done: set up the breadth-first walk from the root
               taken_in    = '0;
               taken_in[0] = 1'b1;
               que_we      = 1'b1;
               que_wa      = '0;
               que_wd      = '0;
               head_in     = '0;
               tail_in     = CW'(1);
            end
         end
         OP_PL_POPW: begin
            cur_in  = stk_rd;
            link_re = 1'b1;
            link_ra = stk_rd;
            srt_re  = 1'b1;
         end
         OP_PL_FILL: begin
            nkey_we = 1'b1;
            fill_in = fill_ff + CW'(1);
            if (right_ok) begin
               taken_in[right_idx] = 1'b1;
               cur_in = right_idx;
            end
         end
         OP_BF_HEAD: begin
            que_re = 1'b1;
            if (!status.q_empty) begin
               head_in = head_ff + CW'(1);
            end else begin
               que_ra = '0;
               k_in   = '0;
            end
         end
         OP_BF_RD: begin
            link_re = 1'b1;
            link_ra = que_rd;
         end
         OP_BF_L: begin
            if (left_ok) begin
               taken_in[left_idx] = 1'b1;
               que_we  = 1'b1;
               tail_in = tail_ff + CW'(1);
            end
         end
         OP_BF_R: begin
            que_wd = right_idx;
            if (right_ok) begin
               taken_in[right_idx] = 1'b1;
               que_we  = 1'b1;
               tail_in = tail_ff + CW'(1);
            end
         end
         OP_OUT_Q: begin
            nkey_re = 1'b1;
         end
         OP_OUT_K: begin
            rvalid_in = 1'b1;
            rkey_in   = nkey_rd;
            rlast_in  = (k_ff + CW'(1)) == tail_ff;
         end
         OP_OUT_WAIT: begin
            if (rsp_fire) begin
               rvalid_in = 1'b0;
               if (rlast_ff) begin
                  count_in = '0;
               end else begin
                  k_in   = k_ff + CW'(1);
                  que_re = 1'b1;
                  que_ra = k_in[IW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      rank_ff  <= rank_in;
      cur_ff   <= cur_in;
      fill_ff  <= fill_in;
      sp_ff    <= sp_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      k_ff     <= k_in;
      taken_ff <= taken_in;
      keyi_ff  <= keyi_in;
      rlast_ff <= rlast_in;
      rkey_ff  <= rkey_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= req_tdata[LW-1:0];
      if (link_re) link_rd <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= KEY_BITS'(req_tdata[LW +: KEY_IN_BITS]);
      if (key_re) key_rd <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (srt_we) srt_mem[srt_wa] <= srt_wd;
      if (srt_re) srt_rd <= srt_mem[srt_ra];
   end

   always_ff @(posedge clock) begin
      if (nkey_we) nkey_mem[nkey_wa] <= nkey_wd;
      if (nkey_re) nkey_rd <= nkey_mem[nkey_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (stk_re) stk_rd <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (que_we) que_mem[que_wa] <= que_wd;
      if (que_re) que_rd <= que_mem[que_ra];
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rkey_ff);
   assign rsp_tlast  = rlast_ff;

endmodule

// ----- rtl/core/bst_shape_fill_level_order.sv -----
// ----------------------------------------------------------------------------
// bst_shape_fill_level_order
// Fills a given tree shape with sorted keys in order, emits them level order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per node, node 0 first (the root). Each
//   carries the left and right child index (-1 for none) and one key; tlast
//   marks the final node. Nodes past MAX_NODES are dropped, their tlast
//   still closes the tree.
//   rsp channel: after the final node, one transaction per reachable node,
//   keys in breadth-first order, tlast on the final key.
//   Loading accepts one node per handshake. The rank sort then compares
//   each key against every key in the key memory; then come the in-order
//   placement (stack and link memory reads), the breadth-first walk, and
//   output of each key when the receiver is ready.
//   req_tready is low from the final node until the last key is taken.
//   A stalled receiver holds the block in output; nothing is lost.
//   Reset empties the tree and returns to loading; no clearing pass.
// ----------------------------------------------------------------------------
module bst_shape_fill_level_order #(
   parameter int MAX_NODES = 64,
   parameter int KEY_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [6:0] left_child, [13:7] right_child, [45:14] key, [47:46] zero
   input  logic [bstf_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] key_out
   output logic [bstf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);
   import bstf_pkg::*;

   cmd_type    cmd;
   status_type status;

   bstf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   bstf_dp #(
      .MAX_NODES (MAX_NODES),
      .KEY_BITS  (KEY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // loading and output never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_last_in_stops: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("still loading after the final node");

   a_last_out_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not back to loading after the final key");

endmodule
